// ===== rtl/rv32de_pkg.sv =====
// rv32de_pkg: opcodes, ALU operation codes, result codes and shared types
// for the RV32I decode and execute block. No dependencies.
`default_nettype none

package rv32de_pkg;

   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SRX  = 3'd5;
   localparam logic [2:0] F3_PRIV = 3'd0;

   localparam logic [11:0] SYS_ECALL  = 12'h000;
   localparam logic [11:0] SYS_EBREAK = 12'h001;

   localparam logic [1:0] WB_ALU = 2'd0;
   localparam logic [1:0] WB_MEM = 2'd1;
   localparam logic [1:0] WB_PC4 = 2'd2;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_ECALL  = 2'd1;
   localparam logic [1:0] EV_EBREAK = 2'd2;
   localparam logic [1:0] EV_FENCE  = 2'd3;

   typedef enum logic [3:0] {
      ALU_ADD  = 4'd0,
      ALU_SUB  = 4'd1,
      ALU_SLL  = 4'd2,
      ALU_SLT  = 4'd3,
      ALU_SLTU = 4'd4,
      ALU_XOR  = 4'd5,
      ALU_SRL  = 4'd6,
      ALU_SRA  = 4'd7,
      ALU_OR   = 4'd8,
      ALU_AND  = 4'd9
   } alu_op_type;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] inst_pc;
      logic [31:0] src1_value;
      logic [31:0] src2_value;
   } req_data_type;

   typedef struct packed {
      logic [4:0]  dest_reg;
      logic        write_enable;
      logic [1:0]  writeback_source;
      logic [31:0] alu_value;
      logic [1:0]  mem_op;
      logic [1:0]  access_size;
      logic        load_unsigned;
      logic [31:0] store_data;
      logic        redirect;
      logic [31:0] next_pc;
      logic [1:0]  system_event;
   } rsp_data_type;

   // decode to execute control
   typedef struct packed {
      alu_op_type  alu_op;
      logic [31:0] op_a;
      logic [31:0] op_b;
      logic        jump;
      logic        taken;
      logic [4:0]  dest_reg;
      logic        write_enable;
      logic [1:0]  writeback_source;
      logic [1:0]  mem_op;
      logic [1:0]  access_size;
      logic        load_unsigned;
      logic [31:0] store_data;
      logic [1:0]  system_event;
   } ctrl_type;

   function automatic alu_op_type funct_op(input logic [2:0] f3, input logic f7_nz);
      alu_op_type op;
      case (f3)
         3'd0:    op = f7_nz ? ALU_SUB : ALU_ADD;
         3'd1:    op = ALU_SLL;
         3'd2:    op = ALU_SLT;
         3'd3:    op = ALU_SLTU;
         3'd4:    op = ALU_XOR;
         3'd5:    op = f7_nz ? ALU_SRA : ALU_SRL;
         3'd6:    op = ALU_OR;
         default: op = ALU_AND;
      endcase
      return op;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/rv32de_req_if.sv =====
// rv32de_req_if: instruction channel, valid/ready with the instruction payload.
// No dependencies.
`default_nettype none

interface rv32de_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction;
   logic [31:0] inst_pc;
   logic [31:0] src1_value;
   logic [31:0] src2_value;

   modport source (output valid, output instruction, output inst_pc,
                   output src1_value, output src2_value, input ready);
   modport sink   (input valid, input instruction, input inst_pc,
                   input src1_value, input src2_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/rv32de_rsp_if.sv =====
// rv32de_rsp_if: result channel, valid/ready with the execute result payload.
// No dependencies.
`default_nettype none

interface rv32de_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  dest_reg;
   logic        write_enable;
   logic [1:0]  writeback_source;
   logic [31:0] alu_value;
   logic [1:0]  mem_op;
   logic [1:0]  access_size;
   logic        load_unsigned;
   logic [31:0] store_data;
   logic        redirect;
   logic [31:0] next_pc;
   logic [1:0]  system_event;

   modport source (output valid, output dest_reg, output write_enable,
                   output writeback_source, output alu_value, output mem_op,
                   output access_size, output load_unsigned, output store_data,
                   output redirect, output next_pc, output system_event,
                   input ready);
   modport sink   (input valid, input dest_reg, input write_enable,
                   input writeback_source, input alu_value, input mem_op,
                   input access_size, input load_unsigned, input store_data,
                   input redirect, input next_pc, input system_event,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/rv32de_decode.sv =====
// rv32de_decode: instruction decode, immediate generation, operand select
// and branch compare. Depends on rv32de_pkg.
`default_nettype none

module rv32de_decode (
   input  rv32de_pkg::req_data_type req_data,
   output rv32de_pkg::ctrl_type     ctrl
);
   import rv32de_pkg::*;

   logic [31:0] inst;
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic        f7_nz;
   logic [4:0]  rd;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] r1;
   logic [31:0] r2;
   logic        wr;
   logic        br_take;

   assign inst  = req_data.instruction;
   assign r1    = req_data.src1_value;
   assign r2    = req_data.src2_value;
   assign opc   = inst[6:0];
   assign f3    = inst[14:12];
   assign f7_nz = |inst[31:25];
   assign rd    = inst[11:7];
   assign imm_i = {{20{inst[31]}}, inst[31:20]};
   assign imm_s = {{20{inst[31]}}, inst[31:25], inst[11:7]};
   assign imm_b = {{19{inst[31]}}, inst[31], inst[7], inst[30:25], inst[11:8], 1'b0};
   assign imm_u = {inst[31:12], 12'h000};
   assign imm_j = {{11{inst[31]}}, inst[31], inst[19:12], inst[20], inst[30:21], 1'b0};

   always_comb begin
      case (f3)
         F3_BEQ:  br_take = (r1 == r2);
         F3_BNE:  br_take = (r1 != r2);
         F3_BLT:  br_take = ($signed(r1) < $signed(r2));
         F3_BGE:  br_take = !($signed(r1) < $signed(r2));
         F3_BLTU: br_take = (r1 < r2);
         F3_BGEU: br_take = (r1 >= r2);
         default: br_take = 1'b0;
      endcase
   end

   always_comb begin
      wr                    = 1'b0;
      ctrl                  = '0;
      ctrl.alu_op           = ALU_ADD;
      ctrl.op_a             = r1;
      ctrl.op_b             = r2;
      ctrl.dest_reg         = rd;
      ctrl.writeback_source = WB_ALU;
      ctrl.mem_op           = MEM_NONE;
      ctrl.system_event     = EV_NONE;
      case (opc)
         OPC_OP: begin
            wr          = 1'b1;
            ctrl.alu_op = funct_op(f3, f7_nz);
         end
         OPC_IMM: begin
            wr = 1'b1;
            if (f3 == F3_SLL || f3 == F3_SRX) begin
               ctrl.alu_op = funct_op(f3, f7_nz);
               ctrl.op_b   = {27'd0, imm_i[4:0]};
            end else begin
               ctrl.alu_op = funct_op(f3, 1'b0);
               ctrl.op_b   = imm_i;
            end
         end
         OPC_LOAD: begin
            wr                    = 1'b1;
            ctrl.writeback_source = WB_MEM;
            ctrl.mem_op           = MEM_LOAD;
            ctrl.access_size      = f3[1:0];
            ctrl.load_unsigned    = f3[2];
            ctrl.op_b             = imm_i;
         end
         OPC_STORE: begin
            ctrl.mem_op      = MEM_STORE;
            ctrl.access_size = f3[1:0];
            ctrl.store_data  = r2;
            ctrl.op_b        = imm_s;
         end
         OPC_BRANCH: begin
            ctrl.op_a  = req_data.inst_pc;
            ctrl.op_b  = imm_b;
            ctrl.taken = br_take;
         end
         OPC_LUI: begin
            wr        = 1'b1;
            ctrl.op_a = '0;
            ctrl.op_b = imm_u;
         end
         OPC_AUIPC: begin
            wr        = 1'b1;
            ctrl.op_a = req_data.inst_pc;
            ctrl.op_b = imm_u;
         end
         OPC_JAL: begin
            wr                    = 1'b1;
            ctrl.writeback_source = WB_PC4;
            ctrl.op_a             = req_data.inst_pc;
            ctrl.op_b             = imm_j;
            ctrl.jump             = 1'b1;
         end
         OPC_JALR: begin
            wr                    = 1'b1;
            ctrl.writeback_source = WB_PC4;
            ctrl.op_b             = imm_i;
            ctrl.jump             = 1'b1;
         end
         OPC_SYSTEM: begin
            if (f3 == F3_PRIV) begin
               if (inst[31:20] == SYS_ECALL) begin
                  ctrl.system_event = EV_ECALL;
               end else if (inst[31:20] == SYS_EBREAK) begin
                  ctrl.system_event = EV_EBREAK;
               end
            end
         end
         OPC_FENCE: begin
            ctrl.system_event = EV_FENCE;
         end
         default: begin
         end
      endcase
      ctrl.write_enable = wr && (rd != 5'd0);
   end

endmodule

`default_nettype wire

// ===== rtl/rv32de_alu.sv =====
// rv32de_alu: ALU and next-pc selection from the decoded control.
// Depends on rv32de_pkg.
`default_nettype none

module rv32de_alu (
   input  rv32de_pkg::ctrl_type     ctrl,
   input  logic [31:0]              inst_pc,
   output rv32de_pkg::rsp_data_type rsp_data
);
   import rv32de_pkg::*;

   logic [31:0] a;
   logic [31:0] b;
   logic [4:0]  sh;
   logic [31:0] val;
   logic [31:0] pc4;

   assign a   = ctrl.op_a;
   assign b   = ctrl.op_b;
   assign sh  = b[4:0];
   assign pc4 = inst_pc + 32'd4;

   always_comb begin
      case (ctrl.alu_op)
         ALU_SUB:  val = a - b;
         ALU_SLL:  val = a << sh;
         ALU_SLT:  val = {31'd0, $signed(a) < $signed(b)};
         ALU_SLTU: val = {31'd0, a < b};
         ALU_XOR:  val = a ^ b;
         ALU_SRL:  val = a >> sh;
         ALU_SRA:  val = $unsigned($signed(a) >>> sh);
         ALU_OR:   val = a | b;
         ALU_AND:  val = a & b;
         default:  val = a + b;
      endcase
   end

   always_comb begin
      rsp_data.dest_reg         = ctrl.dest_reg;
      rsp_data.write_enable     = ctrl.write_enable;
      rsp_data.writeback_source = ctrl.writeback_source;
      rsp_data.alu_value        = val;
      rsp_data.mem_op           = ctrl.mem_op;
      rsp_data.access_size      = ctrl.access_size;
      rsp_data.load_unsigned    = ctrl.load_unsigned;
      rsp_data.store_data       = ctrl.store_data;
      rsp_data.redirect         = ctrl.jump || ctrl.taken;
      rsp_data.system_event     = ctrl.system_event;
      if (ctrl.jump) begin
         rsp_data.next_pc = {val[31:1], 1'b0};
      end else if (ctrl.taken) begin
         rsp_data.next_pc = val;
      end else begin
         rsp_data.next_pc = pc4;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/rv32i_decode_execute.sv =====
// rv32i_decode_execute: top level, input register, decode, ALU, result register.
// Depends on rv32de_pkg, rv32de_req_if, rv32de_rsp_if, rv32de_decode, rv32de_alu.
//
// Decode and execute stage of an RV32I core with two pipeline registers: a
// transfer on req is captured in the input register, decoded and executed by
// combinational logic (one 32-bit adder/shifter/compare path plus the
// pc-plus-four adder), and lands in the result register when the pipeline
// advances, from which it is offered on rsp; throughput is one instruction
// per clock while rsp is ready. The block has no architectural state, no
// configuration and no clearing pass after reset: req_ready is high whenever
// the input register is empty or the pipeline can advance, so one instruction
// is held while a result waits on rsp.
`default_nettype none

module rv32i_decode_execute (
   input  logic                clock,
   input  logic                reset,
   rv32de_req_if.sink          req_ch,
   rv32de_rsp_if.source        rsp_ch
);
   import rv32de_pkg::*;

   logic         s1_valid_ff;
   logic         s1_valid_in;
   req_data_type s1_data_ff;
   req_data_type s1_data_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;
   rsp_data_type exe_data;
   ctrl_type     ctrl;
   logic         advance;
   logic         req_take;

   assign advance  = !rsp_valid_ff || rsp_ch.ready;
   assign req_take = !s1_valid_ff || advance;
   assign req_ch.ready = req_take;

   rv32de_decode u_decode (
      .req_data (s1_data_ff),
      .ctrl     (ctrl)
   );

   rv32de_alu u_alu (
      .ctrl     (ctrl),
      .inst_pc  (s1_data_ff.inst_pc),
      .rsp_data (exe_data)
   );

   always_comb begin
      s1_valid_in = req_take ? req_ch.valid : s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (req_take && req_ch.valid) begin
         s1_data_in.instruction = req_ch.instruction;
         s1_data_in.inst_pc     = req_ch.inst_pc;
         s1_data_in.src1_value  = req_ch.src1_value;
         s1_data_in.src2_value  = req_ch.src2_value;
      end
      rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;
      rsp_data_in  = (advance && s1_valid_ff) ? exe_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff  <= s1_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.dest_reg         = rsp_data_ff.dest_reg;
   assign rsp_ch.write_enable     = rsp_data_ff.write_enable;
   assign rsp_ch.writeback_source = rsp_data_ff.writeback_source;
   assign rsp_ch.alu_value        = rsp_data_ff.alu_value;
   assign rsp_ch.mem_op           = rsp_data_ff.mem_op;
   assign rsp_ch.access_size      = rsp_data_ff.access_size;
   assign rsp_ch.load_unsigned    = rsp_data_ff.load_unsigned;
   assign rsp_ch.store_data       = rsp_data_ff.store_data;
   assign rsp_ch.redirect         = rsp_data_ff.redirect;
   assign rsp_ch.next_pc          = rsp_data_ff.next_pc;
   assign rsp_ch.system_event     = rsp_data_ff.system_event;

   // no write-back to x0
   a_no_x0_write : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.write_enable |-> rsp_data_ff.dest_reg != 5'd0)
      else $error("write enable with x0 destination");

   // stores never write back
   a_store_no_wb : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.mem_op == MEM_STORE |-> !rsp_data_ff.write_enable)
      else $error("store with write enable");

   // jump targets are halfword aligned
   a_jump_align : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.writeback_source == WB_PC4
      |-> rsp_data_ff.redirect && !rsp_data_ff.next_pc[0])
      else $error("jump without redirect or with odd target");

   // an occupied input stage moves to the result register when it advances
   a_stage_move : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && advance |=> rsp_valid_ff)
      else $error("instruction lost between stages");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== sim/rv32i_decode_execute_test.sv =====
`timescale 1ns / 1ps
// rv32i_decode_execute_test: self-checking testbench for the RV32I decode and execute stage.
// Needs rv32de_pkg, rv32de_req_if, rv32de_rsp_if and rv32i_decode_execute.
// Instructions go in through a queue-fed driver; every transfer out is checked against a model.

module rv32i_decode_execute_test;
   import rv32de_pkg::*;

   localparam int RAND_PER_PHASE = 530;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 10;

   localparam logic [2:0] F3_ADD     = 3'd0;
   localparam logic [2:0] F3_SLT     = 3'd2;
   localparam logic [2:0] F3_SLTU    = 3'd3;
   localparam logic [2:0] F3_XOR     = 3'd4;
   localparam logic [2:0] F3_OR      = 3'd6;
   localparam logic [2:0] F3_AND     = 3'd7;
   localparam logic [2:0] F3_LBU     = 3'd4;
   localparam logic [2:0] F3_SW      = 3'd2;
   localparam logic [2:0] F3_BR_NONE = 3'd2;
   localparam logic [6:0] F7_BASE    = 7'h00;
   localparam logic [6:0] F7_ALT     = 7'h20;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rv32de_req_if req_bus ();
   rv32de_rsp_if rsp_bus ();

   rv32i_decode_execute i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   req_data_type instr_queue[$];
   rsp_data_type results_due[$];

   int          send_idle_pct = 11;
   int          recv_idle_pct = 52;
   logic        hold_req      = 1'b0;
   logic        hold_served   = 1'b0;
   int          hold_left     = 0;
   logic        req_taken     = 1'b0;
   int          quiet_cycles  = 0;
   int unsigned mismatches    = 0;
   int unsigned n_results     = 0;
   int unsigned n_redirects   = 0;
   int unsigned n_mem_ops     = 0;
   int unsigned n_sys_events  = 0;
   int unsigned n_directed    = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] alu_eval(input alu_op_type op, input logic [31:0] a,
                                            input logic [31:0] b);
      logic [31:0] res;
      case (op)
         ALU_SUB:  res = a - b;
         ALU_SLL:  res = a << b[4:0];
         ALU_SLT:  res = {31'b0, $signed(a) < $signed(b)};
         ALU_SLTU: res = {31'b0, a < b};
         ALU_XOR:  res = a ^ b;
         ALU_SRL:  res = a >> b[4:0];
         ALU_SRA:  res = $signed(a) >>> b[4:0];
         ALU_OR:   res = a | b;
         ALU_AND:  res = a & b;
         default:  res = a + b;
      endcase
      return res;
   endfunction

   function automatic rsp_data_type execute_instr(input req_data_type it);
      rsp_data_type r;
      logic [31:0]  ins, a, b, pc;
      logic [31:0]  imm_i, imm_s, imm_b, imm_u, imm_j;
      logic [6:0]   opc;
      logic [2:0]   f3;
      logic         alt, wr, take;
      alu_op_type   op;
      ins   = it.instruction;
      pc    = it.inst_pc;
      a     = it.src1_value;
      b     = it.src2_value;
      opc   = ins[6:0];
      f3    = ins[14:12];
      imm_i = {{20{ins[31]}}, ins[31:20]};
      imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};
      imm_b = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
      imm_u = {ins[31:12], 12'b0};
      imm_j = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
      // SUB only on OP, SRA on OP and OP-IMM
      alt   = (opc == OPC_OP) ? (|ins[31:25]) : ((f3 == F3_SRX) && (|ins[31:25]));
      op    = ALU_ADD;
      case (f3)
         F3_ADD:  op = alt ? ALU_SUB : ALU_ADD;
         F3_SLL:  op = ALU_SLL;
         F3_SLT:  op = ALU_SLT;
         F3_SLTU: op = ALU_SLTU;
         F3_XOR:  op = ALU_XOR;
         F3_SRX:  op = alt ? ALU_SRA : ALU_SRL;
         F3_OR:   op = ALU_OR;
         F3_AND:  op = ALU_AND;
         default: op = ALU_ADD;
      endcase
      r                  = '0;
      r.dest_reg         = ins[11:7];
      r.writeback_source = WB_ALU;
      r.mem_op           = MEM_NONE;
      r.system_event     = EV_NONE;
      r.alu_value        = a + b;
      r.next_pc          = pc + 32'd4;
      wr                 = 1'b0;
      take               = 1'b0;
      case (opc)
         OPC_OP: begin
            wr = 1'b1;
            r.alu_value = alu_eval(op, a, b);
         end
         OPC_IMM: begin
            wr = 1'b1;
            r.alu_value = alu_eval(op, a, imm_i);
         end
         OPC_LOAD: begin
            wr = 1'b1;
            r.writeback_source = WB_MEM;
            r.mem_op = MEM_LOAD;
            r.access_size = f3[1:0];
            r.load_unsigned = f3[2];
            r.alu_value = a + imm_i;
         end
         OPC_STORE: begin
            r.mem_op = MEM_STORE;
            r.access_size = f3[1:0];
            r.store_data = b;
            r.alu_value = a + imm_s;
         end
         OPC_BRANCH: begin
            r.alu_value = pc + imm_b;
            case (f3)
               F3_BEQ:  take = (a == b);
               F3_BNE:  take = (a != b);
               F3_BLT:  take = $signed(a) < $signed(b);
               F3_BGE:  take = !($signed(a) < $signed(b));
               F3_BLTU: take = (a < b);
               F3_BGEU: take = (a >= b);
               default: take = 1'b0;
            endcase
            if (take) begin
               r.redirect = 1'b1;
               r.next_pc = r.alu_value;
            end
         end
         OPC_LUI: begin
            wr = 1'b1;
            r.alu_value = imm_u;
         end
         OPC_AUIPC: begin
            wr = 1'b1;
            r.alu_value = pc + imm_u;
         end
         OPC_JAL, OPC_JALR: begin
            wr = 1'b1;
            r.writeback_source = WB_PC4;
            r.alu_value = (opc == OPC_JAL) ? pc + imm_j : a + imm_i;
            r.redirect = 1'b1;
            r.next_pc = {r.alu_value[31:1], 1'b0};
         end
         OPC_SYSTEM: begin
            if (f3 == F3_PRIV && ins[31:20] == SYS_ECALL)
               r.system_event = EV_ECALL;
            else if (f3 == F3_PRIV && ins[31:20] == SYS_EBREAK)
               r.system_event = EV_EBREAK;
         end
         OPC_FENCE: r.system_event = EV_FENCE;
         default: ;
      endcase
      r.write_enable = wr && (ins[11:7] != 5'd0);
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      logic [31:0] w;
      case ($urandom_range(0, 9))
         0:       w = 32'h0000_0000;
         1:       w = 32'hffff_ffff;
         2:       w = 32'h8000_0000;
         3:       w = 32'h7fff_ffff;
         4:       w = 32'h0000_0001;
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // mostly valid opcodes with random fields, one in ten fully random words
   function automatic req_data_type random_instr();
      req_data_type r;
      logic [31:0]  ins;
      ins = $urandom;
      if ($urandom_range(0, 9) != 0) begin
         case ($urandom_range(0, 10))
            0:       ins[6:0] = OPC_LOAD;
            1:       ins[6:0] = OPC_FENCE;
            2:       ins[6:0] = OPC_IMM;
            3:       ins[6:0] = OPC_AUIPC;
            4:       ins[6:0] = OPC_STORE;
            5:       ins[6:0] = OPC_OP;
            6:       ins[6:0] = OPC_LUI;
            7:       ins[6:0] = OPC_BRANCH;
            8:       ins[6:0] = OPC_JALR;
            9:       ins[6:0] = OPC_JAL;
            default: ins[6:0] = OPC_SYSTEM;
         endcase
         if ((ins[6:0] == OPC_OP || ins[6:0] == OPC_IMM) && $urandom_range(0, 3) != 0)
            ins[31:25] = $urandom_range(0, 1) ? F7_ALT : F7_BASE;
         if (ins[6:0] == OPC_SYSTEM && $urandom_range(0, 1)) begin
            ins[14:12] = F3_PRIV;
            case ($urandom_range(0, 2))
               0:       ins[31:20] = SYS_ECALL;
               1:       ins[31:20] = SYS_EBREAK;
               default: ;
            endcase
         end
      end
      r.instruction = ins;
      r.inst_pc     = pick_word();
      r.src1_value  = pick_word();
      r.src2_value  = ($urandom_range(0, 3) == 0) ? r.src1_value : pick_word();
      return r;
   endfunction

   task automatic queue_instr(input logic [31:0] ins, input logic [31:0] pc,
                              input logic [31:0] a, input logic [31:0] b);
      req_data_type r;
      r.instruction = ins;
      r.inst_pc     = pc;
      r.src1_value  = a;
      r.src2_value  = b;
      instr_queue.push_back(r);
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic wait_drained();
      while (instr_queue.size() != 0 || req_bus.valid || results_due.size() != 0)
         @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin : drive_instr
      req_data_type next_instr;
      if (reset)
         req_bus.valid <= 1'b0;
      else if (!req_bus.valid || req_taken) begin
         if (instr_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            next_instr = instr_queue.pop_front();
            req_bus.valid       <= 1'b1;
            req_bus.instruction <= next_instr.instruction;
            req_bus.inst_pc     <= next_instr.inst_pc;
            req_bus.src1_value  <= next_instr.src1_value;
            req_bus.src2_value  <= next_instr.src2_value;
         end else
            req_bus.valid <= 1'b0;
      end
   end

   // result sink, with one long hold-off on request
   always @(negedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else if (hold_req && !hold_served) begin
         hold_served = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // monitor
   always @(posedge clock) begin : monitor
      req_data_type taken_instr;
      rsp_data_type want, got;
      if (reset)
         req_taken <= 1'b0;
      else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            taken_instr.instruction = req_bus.instruction;
            taken_instr.inst_pc     = req_bus.inst_pc;
            taken_instr.src1_value  = req_bus.src1_value;
            taken_instr.src2_value  = req_bus.src2_value;
            results_due.push_back(execute_instr(taken_instr));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (results_due.size() == 0) begin
               $error("result transfer with no instruction outstanding");
               mismatches++;
            end else begin
               want = results_due.pop_front();
               got.dest_reg         = rsp_bus.dest_reg;
               got.write_enable     = rsp_bus.write_enable;
               got.writeback_source = rsp_bus.writeback_source;
               got.alu_value        = rsp_bus.alu_value;
               got.mem_op           = rsp_bus.mem_op;
               got.access_size      = rsp_bus.access_size;
               got.load_unsigned    = rsp_bus.load_unsigned;
               got.store_data       = rsp_bus.store_data;
               got.redirect         = rsp_bus.redirect;
               got.next_pc          = rsp_bus.next_pc;
               got.system_event     = rsp_bus.system_event;
               check_field("dest_reg", 32'(want.dest_reg), 32'(got.dest_reg));
               check_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
               check_field("writeback_source", 32'(want.writeback_source),
                           32'(got.writeback_source));
               check_field("alu_value", want.alu_value, got.alu_value);
               check_field("mem_op", 32'(want.mem_op), 32'(got.mem_op));
               check_field("access_size", 32'(want.access_size), 32'(got.access_size));
               check_field("load_unsigned", 32'(want.load_unsigned), 32'(got.load_unsigned));
               check_field("store_data", want.store_data, got.store_data);
               check_field("redirect", 32'(want.redirect), 32'(got.redirect));
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("system_event", 32'(want.system_event), 32'(got.system_event));
               n_results++;
               if (want.redirect) n_redirects++;
               if (want.mem_op != MEM_NONE) n_mem_ops++;
               if (want.system_event != EV_NONE) n_sys_events++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("rv32i_decode_execute regression: fail");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : stimulus
      int k;
      req_bus.valid       = 1'b0;
      req_bus.instruction = '0;
      req_bus.inst_pc     = '0;
      req_bus.src1_value  = '0;
      req_bus.src2_value  = '0;
      rsp_bus.ready       = 1'b0;

      // directed
      queue_instr(32'h0000_0000, 32'h0, 32'h0, 32'h0);
      queue_instr(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      queue_instr({F7_BASE, 5'd2, 5'd1, F3_ADD, 5'd1, OPC_OP}, 32'h100, 32'h7fff_ffff, 32'h1);
      queue_instr({F7_ALT, 5'd2, 5'd1, F3_ADD, 5'd0, OPC_OP}, 32'h104, 32'h0, 32'h1);
      queue_instr({7'h01, 5'd2, 5'd1, F3_ADD, 5'd31, OPC_OP}, 32'h108, 32'h5, 32'h7);
      queue_instr({F7_BASE, 5'd2, 5'd1, F3_SLL, 5'd3, OPC_OP}, 32'h10c, 32'h1, 32'd33);
      queue_instr({F7_BASE, 5'd2, 5'd1, F3_SLT, 5'd3, OPC_OP}, 32'h110, 32'h8000_0000, 32'h1);
      queue_instr({F7_BASE, 5'd2, 5'd1, F3_SLTU, 5'd3, OPC_OP}, 32'h114, 32'h8000_0000, 32'h1);
      queue_instr({F7_BASE, 5'd2, 5'd1, F3_SRX, 5'd3, OPC_OP}, 32'h118, 32'h8000_0000, 32'd31);
      queue_instr({F7_ALT, 5'd2, 5'd1, F3_SRX, 5'd3, OPC_OP}, 32'h11c, 32'h8000_0000, 32'd63);
      queue_instr({12'hfff, 5'd1, F3_ADD, 5'd4, OPC_IMM}, 32'h120, 32'h0, 32'h5);
      queue_instr({F7_ALT, 5'd4, 5'd1, F3_SRX, 5'd4, OPC_IMM}, 32'h124, 32'hf000_0000, 32'h0);
      queue_instr({7'h7f, 5'd31, 5'd1, F3_SLL, 5'd4, OPC_IMM}, 32'h128, 32'h1, 32'h0);
      queue_instr({12'hfff, 5'd1, F3_SLTU, 5'd4, OPC_IMM}, 32'h12c, 32'h5, 32'h0);
      queue_instr({12'hffc, 5'd1, F3_LBU, 5'd5, OPC_LOAD}, 32'h130, 32'h1000, 32'h0);
      queue_instr({7'h7f, 5'd2, 5'd1, F3_SW, 5'h1f, OPC_STORE}, 32'h134, 32'h0, 32'hdead_beef);
      queue_instr({1'b1, 6'h3f, 5'd2, 5'd1, F3_BEQ, 4'hf, 1'b1, OPC_BRANCH},
                  32'h0, 32'h1234, 32'h1234);
      queue_instr({1'b0, 6'h00, 5'd2, 5'd1, F3_BR_NONE, 4'h4, 1'b0, OPC_BRANCH},
                  32'h200, 32'h1234, 32'h1234);
      queue_instr({1'b0, 6'h3f, 5'd2, 5'd1, F3_BGE, 4'hf, 1'b1, OPC_BRANCH},
                  32'h204, 32'h8000_0000, 32'h0);
      queue_instr({1'b0, 6'h00, 5'd2, 5'd1, F3_BLTU, 4'h8, 1'b0, OPC_BRANCH},
                  32'hffff_fff0, 32'h0, 32'hffff_ffff);
      queue_instr({20'hfffff, 5'd6, OPC_LUI}, 32'h208, 32'h0, 32'h0);
      queue_instr({20'h00001, 5'd7, OPC_AUIPC}, 32'hffff_fffc, 32'h0, 32'h0);
      queue_instr({1'b1, 10'h3ff, 1'b1, 8'hff, 5'd1, OPC_JAL}, 32'hffff_ffff, 32'h0, 32'h0);
      queue_instr({12'h001, 5'd1, F3_ADD, 5'd1, OPC_JALR}, 32'h20c, 32'h100, 32'h0);
      queue_instr({SYS_ECALL, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM}, 32'h210, 32'h1, 32'h2);
      queue_instr({SYS_EBREAK, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM}, 32'h214, 32'h1, 32'h2);
      queue_instr({SYS_EBREAK, 5'd1, F3_SLL, 5'd3, OPC_SYSTEM}, 32'h218, 32'h1, 32'h2);
      queue_instr({12'h0ff, 5'd0, F3_ADD, 5'd9, OPC_FENCE}, 32'h21c, 32'h3, 32'h4);
      n_directed = instr_queue.size();

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (k = 0; k < RAND_PER_PHASE; k++) instr_queue.push_back(random_instr());
      wait_drained();

      send_idle_pct = 52;
      recv_idle_pct = 11;
      for (k = 0; k < RAND_PER_PHASE; k++) instr_queue.push_back(random_instr());
      wait_drained();

      // back to back, opening with a long result stall to back the pipe up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req = 1'b1;
      for (k = 0; k < RAND_PER_PHASE; k++) instr_queue.push_back(random_instr());
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results (%0d directed); %0d redirects, %0d loads/stores,",
               n_results, n_directed, n_redirects, n_mem_ops);
      $display("%0d system events; sender-idle, receiver-idle, back-to-back, %0d-cycle stall.",
               n_sys_events, HOLD_CYCLES);
      if (mismatches == 0 && results_due.size() == 0)
         $display("rv32i_decode_execute regression: pass");
      else
         $display("rv32i_decode_execute regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rv32de_pkg.sv
rtl/rv32de_req_if.sv
rtl/rv32de_rsp_if.sv
rtl/rv32de_decode.sv
rtl/rv32de_alu.sv
rtl/rv32i_decode_execute.sv
sim/rv32i_decode_execute_test.sv
